### hdl/assert_macros.svh
// Assertion shorthands, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(label_, ante_, cons_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error("lps: assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(label_, ante_, cons_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |-> (cons_)) \
    else $error("lps: assertion failed");

`endif

### hdl/lps_pkg.sv
package lps_pkg;

  localparam int unsigned MAX_LEN_DEF = 16;
  localparam int unsigned ELEM_W_DEF  = 16;

  localparam int unsigned LEN_W   = 5;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned POS_W   = 4;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PSCAN = 6'b000010,
    ST_SSCAN = 6'b000100,
    ST_SWAP  = 6'b001000,
    ST_REV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

endpackage

### hdl/lps_ram.sv
module lps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lexicographic_permutation_stepper.sv
// Lexicographic permutation stepper.
// Input channel (in_valid_i / in_stall_o): a load word writes value_i at index_i
// and gives no output; a step word moves the first length elements to their next
// (direction_i = 0) or previous (direction_i = 1) permutation, then emits them.
// Output channel (out_valid_o / out_stall_i): one word per element, position
// 0 up to length-1, last_o on the final one, changed_o = 0 when no pivot exists.
// Config channel (cfg_valid_i / cfg_ready_o) sets length (0 acts as 1, above
// MaxLen as MaxLen); write it only when idle. A load is taken while idle. A step
// of n elements runs through one element RAM (one read port, one write port)
// and one shared comparator: pivot scan (straight to emit if none), successor
// scan, swap (two writes), suffix reversal pair by pair (read low, read high,
// write low, write high), then one output word per cycle unless stalled.
// in_stall_o is high from a step until its last word sits in the output
// register; the next word is taken while that last word still waits.
// A stalled output holds its word and pauses the emit reads.
// Reset returns to idle with length 16; element contents are undefined until loaded.
module lexicographic_permutation_stepper #(
  parameter int unsigned MaxLen    = lps_pkg::MAX_LEN_DEF,
  parameter int unsigned ElemWidth = lps_pkg::ELEM_W_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [lps_pkg::INDEX_W-1:0]        index_i,
  input  logic signed [lps_pkg::VALUE_W-1:0] value_i,
  input  logic                               direction_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lps_pkg::POS_W-1:0]          position_o,
  output logic signed [lps_pkg::VALUE_W-1:0] element_o,
  output logic                               changed_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lps_pkg::LEN_W-1:0]          cfg_length_i
);

  import lps_pkg::*;

  localparam int unsigned AW = $clog2(MaxLen);

  state_e state_q, state_d;

  logic [LEN_W-1:0] cfg_len_q;
  logic [AW-1:0]    len_last;

  logic [AW-1:0] last_q, last_d;
  logic [AW-1:0] c_q, c_d;
  logic [AW-1:0] rt_q, rt_d;
  logic [AW-1:0] piv_q, piv_d;
  logic [AW-1:0] jx_q, jx_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [AW-1:0] ptag_q, ptag_d;
  logic [AW-1:0] lo_nx, hi_nx, piv_nx;
  logic          go_q, go_d;
  logic          rv_q, rv_d;
  logic          pend_q, pend_d;
  logic          chg_q, chg_d;
  logic          dir_q, dir_d;
  logic [1:0]    ph_q, ph_d;

  logic signed [ElemWidth-1:0] prev_q, prev_d;
  logic signed [ElemWidth-1:0] pval_q, pval_d;
  logic signed [ElemWidth-1:0] jval_q, jval_d;
  logic signed [ElemWidth-1:0] t_q, t_d;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic signed [ElemWidth-1:0] ram_wdata;
  logic signed [ElemWidth-1:0] ram_rdata;

  logic signed [ElemWidth-1:0] cmp_a, cmp_b, cmp_x, cmp_y;
  logic                        ord;

  logic in_accept, idx_ok, move, issue_em;

  logic                        ov_q;
  logic [POS_W-1:0]            pos_q;
  logic signed [VALUE_W-1:0]   elem_q;
  logic                        chgo_q, lastf_q;

  lps_ram #(
    .Width(ElemWidth),
    .Depth(MaxLen)
  ) u_lps_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign idx_ok      = int'(index_i) < int'(MaxLen);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_len_q == '0) begin
      len_last = '0;
    end else if (int'(cfg_len_q) > int'(MaxLen)) begin
      len_last = AW'(MaxLen - 1);
    end else begin
      len_last = AW'(cfg_len_q - LEN_W'(1));
    end
  end

  // shared comparator: "a comes before b" in the chosen order
  assign cmp_a = (state_q == ST_SSCAN) ? pval_q : ram_rdata;
  assign cmp_b = (state_q == ST_SSCAN) ? ram_rdata : prev_q;
  assign cmp_x = dir_q ? cmp_b : cmp_a;
  assign cmp_y = dir_q ? cmp_a : cmp_b;
  assign ord   = cmp_x < cmp_y;

  assign lo_nx  = lo_q + AW'(1);
  assign hi_nx  = hi_q - AW'(1);
  assign piv_nx = piv_q + AW'(1);

  assign move     = (state_q == ST_EMIT) && pend_q && (!ov_q || !out_stall_i);
  assign issue_em = go_q && (!pend_q || move);

  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    c_d       = c_q;
    rt_d      = rt_q;
    piv_d     = piv_q;
    jx_d      = jx_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ptag_d    = ptag_q;
    go_d      = go_q;
    rv_d      = 1'b0;
    pend_d    = pend_q;
    chg_d     = chg_q;
    dir_d     = dir_q;
    ph_d      = ph_q;
    prev_d    = prev_q;
    pval_d    = pval_q;
    jval_d    = jval_q;
    t_d       = t_q;
    ram_we    = 1'b0;
    ram_waddr = lo_q;
    ram_wdata = t_q;
    ram_re    = 1'b0;
    ram_raddr = c_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (kind_i == KIND_LOAD) begin
            ram_we    = idx_ok;
            ram_waddr = AW'(index_i);
            ram_wdata = ElemWidth'(value_i);
          end else begin
            dir_d  = direction_i;
            last_d = len_last;
            go_d   = 1'b1;
            if (len_last == '0) begin
              chg_d   = 1'b0;
              c_d     = '0;
              state_d = ST_EMIT;
            end else begin
              c_d     = len_last;
              state_d = ST_PSCAN;
            end
          end
        end
      end
      ST_PSCAN, ST_SSCAN: begin
        if (go_q) begin
          ram_re = 1'b1;
          rv_d   = 1'b1;
          rt_d   = c_q;
          if (c_q == '0) begin
            go_d = 1'b0;
          end else begin
            c_d = c_q - AW'(1);
          end
        end
        if (rv_q) begin
          if (state_q == ST_PSCAN) begin
            if (rt_q == last_q) begin
              prev_d = ram_rdata;
            end else if (ord) begin
              piv_d   = rt_q;
              pval_d  = ram_rdata;
              rv_d    = 1'b0;
              c_d     = last_q;
              go_d    = 1'b1;
              state_d = ST_SSCAN;
            end else begin
              prev_d = ram_rdata;
              if (rt_q == '0) begin
                chg_d   = 1'b0;
                c_d     = '0;
                go_d    = 1'b1;
                rv_d    = 1'b0;
                state_d = ST_EMIT;
              end
            end
          end else if (ord) begin
            jx_d    = rt_q;
            jval_d  = ram_rdata;
            rv_d    = 1'b0;
            ph_d    = 2'd0;
            state_d = ST_SWAP;
          end
        end
      end
      ST_SWAP: begin
        ram_we = 1'b1;
        if (ph_q == 2'd0) begin
          ram_waddr = piv_q;
          ram_wdata = jval_q;
          ph_d      = 2'd1;
        end else begin
          ram_waddr = jx_q;
          ram_wdata = pval_q;
          lo_d      = piv_nx;
          hi_d      = last_q;
          ph_d      = 2'd0;
          chg_d     = 1'b1;
          if (piv_nx < last_q) begin
            state_d = ST_REV;
          end else begin
            c_d     = '0;
            go_d    = 1'b1;
            state_d = ST_EMIT;
          end
        end
      end
      ST_REV: begin
        case (ph_q)
          2'd0: begin
            ram_re    = 1'b1;
            ram_raddr = lo_q;
            ph_d      = 2'd1;
          end
          2'd1: begin
            ram_re    = 1'b1;
            ram_raddr = hi_q;
            t_d       = ram_rdata;
            ph_d      = 2'd2;
          end
          2'd2: begin
            ram_we    = 1'b1;
            ram_waddr = lo_q;
            ram_wdata = ram_rdata;
            ph_d      = 2'd3;
          end
          default: begin
            ram_we    = 1'b1;
            ram_waddr = hi_q;
            ram_wdata = t_q;
            lo_d      = lo_nx;
            hi_d      = hi_nx;
            ph_d      = 2'd0;
            if (!(lo_nx < hi_nx)) begin
              c_d     = '0;
              go_d    = 1'b1;
              state_d = ST_EMIT;
            end
          end
        endcase
      end
      ST_EMIT: begin
        if (issue_em) begin
          ram_re    = 1'b1;
          ram_raddr = c_q;
          pend_d    = 1'b1;
          ptag_d    = c_q;
          if (c_q == last_q) begin
            go_d = 1'b0;
          end else begin
            c_d = c_q + AW'(1);
          end
        end else if (move) begin
          pend_d = 1'b0;
        end
        if (move && (ptag_q == last_q)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_len_q <= LEN_RESET;
      go_q      <= 1'b0;
      rv_q      <= 1'b0;
      pend_q    <= 1'b0;
      ph_q      <= 2'd0;
      ov_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      rv_q    <= rv_d;
      pend_q  <= pend_d;
      ph_q    <= ph_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_len_q <= cfg_length_i;
      end
      if (move) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    c_q    <= c_d;
    rt_q   <= rt_d;
    piv_q  <= piv_d;
    jx_q   <= jx_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    ptag_q <= ptag_d;
    chg_q  <= chg_d;
    dir_q  <= dir_d;
    prev_q <= prev_d;
    pval_q <= pval_d;
    jval_q <= jval_d;
    t_q    <= t_d;
    if (move) begin
      pos_q   <= POS_W'(ptag_q);
      elem_q  <= VALUE_W'(ram_rdata);
      chgo_q  <= chg_q;
      lastf_q <= (ptag_q == last_q);
    end
  end

  assign out_valid_o = ov_q;
  assign position_o  = pos_q;
  assign element_o   = elem_q;
  assign changed_o   = chgo_q;
  assign last_o      = lastf_q;

endmodule

### hdl/lps_checker.sv
`include "assert_macros.svh"

module lps_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               kind_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [lps_pkg::POS_W-1:0]          position_o,
  input logic signed [lps_pkg::VALUE_W-1:0] element_o,
  input logic                               changed_o,
  input logic                               last_o
);

  import lps_pkg::*;

  `LPS_ASSERT_NEXT(step_goes_busy_a, in_valid_i && !in_stall_o && kind_i == KIND_STEP, in_stall_o)

  `LPS_ASSERT_NEXT(out_hold_a, out_valid_o && out_stall_i, out_valid_o && $stable(element_o) && $stable(position_o) && $stable(last_o))

  `LPS_ASSERT_NEXT(pos_step_a, out_valid_o && !out_stall_i && !last_o, !out_valid_o || (position_o == POS_W'($past(position_o) + POS_W'(1)) && changed_o == $past(changed_o)))

  `LPS_ASSERT_NEXT(run_starts_at_zero_a, out_valid_o && !out_stall_i && last_o, !out_valid_o || position_o == '0)

  `LPS_ASSERT_SAME(busy_mid_run_a, out_valid_o && !last_o, in_stall_o)

endmodule

bind lexicographic_permutation_stepper lps_checker u_lps_checker (.*);

### tb/lexicographic_permutation_stepper_test.sv
module lexicographic_permutation_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;

  localparam int MaxLen      = 16;
  localparam int SettleCyc   = 100;
  localparam int HoldCyc     = 400;
  localparam int RandItems   = 80;
  localparam int LimitCyc    = 400000;
  localparam int NumDirected = 29;

  localparam logic DIR_NEXT = 1'b0;
  localparam logic DIR_PREV = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] elem;
    logic                      changed;
    logic                      last;
  } out_word_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_STEP, ROW_LEN} row_e;

  typedef struct packed {
    row_e                      op;
    logic [INDEX_W-1:0]        idx;
    logic signed [VALUE_W-1:0] val;
    logic                      dir;
    logic                      typed;
    out_word_t                 want;
  } row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      kind_i;
  logic [INDEX_W-1:0]        index_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      direction_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [POS_W-1:0]          position_o;
  logic signed [VALUE_W-1:0] element_o;
  logic                      changed_o;
  logic                      last_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [LEN_W-1:0]          cfg_length_i;

  lexicographic_permutation_stepper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .direction_i (direction_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .element_o   (element_o),
    .changed_o   (changed_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_length_i(cfg_length_i)
  );

  // model state
  logic signed [VALUE_W-1:0] elem_mem [MaxLen];
  logic [LEN_W-1:0]          len_reg;
  out_word_t                 perm_words_q [$];

  int fail_cnt;
  int hold_reqs;
  int burst_left;

  // ascending load, then edge steps, length clamps and duplicates
  row_t dir_tab [NumDirected] = '{
    '{ROW_LOAD, 4'd0,  16'h8000, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd1,  16'hFED4, DIR_PREV, 1'b0, '0},
    '{ROW_LOAD, 4'd2,  16'hFFFE, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd3,  16'hFFFF, DIR_PREV, 1'b0, '0},
    '{ROW_LOAD, 4'd4,  16'h0000, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd5,  16'h0001, DIR_PREV, 1'b0, '0},
    '{ROW_LOAD, 4'd6,  16'h0002, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd7,  16'h0003, DIR_PREV, 1'b0, '0},
    '{ROW_LOAD, 4'd8,  16'h0005, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd9,  16'h0008, DIR_PREV, 1'b0, '0},
    '{ROW_LOAD, 4'd10, 16'h000D, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd11, 16'h0064, DIR_PREV, 1'b0, '0},
    '{ROW_LOAD, 4'd12, 16'h03E8, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd13, 16'h1234, DIR_PREV, 1'b0, '0},
    '{ROW_LOAD, 4'd14, 16'h5555, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd15, 16'h7FFF, DIR_PREV, 1'b0, '0},
    '{ROW_STEP, 4'd0,  16'h0000, DIR_PREV, 1'b0, '0},
    '{ROW_STEP, 4'd15, 16'hFFFF, DIR_NEXT, 1'b0, '0},
    '{ROW_LEN,  4'd0,  16'h0000, DIR_NEXT, 1'b0, '0},
    '{ROW_STEP, 4'd0,  16'h0000, DIR_NEXT, 1'b1, '{4'd0, 16'h8000, 1'b0, 1'b1}},
    '{ROW_STEP, 4'd0,  16'h0000, DIR_PREV, 1'b1, '{4'd0, 16'h8000, 1'b0, 1'b1}},
    '{ROW_LEN,  4'd0,  16'h001F, DIR_NEXT, 1'b0, '0},
    '{ROW_STEP, 4'd0,  16'h0000, DIR_NEXT, 1'b0, '0},
    '{ROW_LEN,  4'd0,  16'h0002, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd1,  16'h8000, DIR_NEXT, 1'b0, '0},
    '{ROW_STEP, 4'd0,  16'h0000, DIR_NEXT, 1'b0, '0},
    '{ROW_LOAD, 4'd1,  16'h0007, DIR_NEXT, 1'b0, '0},
    '{ROW_STEP, 4'd0,  16'h0000, DIR_PREV, 1'b0, '0},
    '{ROW_STEP, 4'd0,  16'h0000, DIR_NEXT, 1'b0, '0}
  };

  function automatic logic precedes(logic signed [VALUE_W-1:0] a,
                                    logic signed [VALUE_W-1:0] b, logic prev);
    return prev ? (a > b) : (a < b);
  endfunction

  function automatic int used_len();
    if (len_reg == 0) return 1;
    if (len_reg > MaxLen) return MaxLen;
    return int'(len_reg);
  endfunction

  function automatic logic permute(int n, logic prev);
    int i;
    int j;
    int lo;
    int hi;
    logic signed [VALUE_W-1:0] t;
    if (n < 2) return 1'b0;
    i = n - 1;
    while (i > 0 && !precedes(elem_mem[i-1], elem_mem[i], prev)) i--;
    if (i == 0) return 1'b0;
    i--;
    j = n - 1;
    while (j > i && !precedes(elem_mem[i], elem_mem[j], prev)) j--;
    t = elem_mem[i];
    elem_mem[i] = elem_mem[j];
    elem_mem[j] = t;
    lo = i + 1;
    hi = n - 1;
    while (lo < hi) begin
      t = elem_mem[lo];
      elem_mem[lo] = elem_mem[hi];
      elem_mem[hi] = t;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  function automatic void predict_step(logic prev, logic typed, out_word_t typed_word);
    int n;
    logic moved;
    out_word_t w;
    n = used_len();
    moved = permute(n, prev);
    if (typed) begin
      perm_words_q.push_back(typed_word);
    end else begin
      for (int k = 0; k < n; k++) begin
        w.pos     = POS_W'(k);
        w.elem    = elem_mem[k];
        w.changed = moved;
        w.last    = (k == n - 1);
        perm_words_q.push_back(w);
      end
    end
  endfunction

  task automatic note_mismatch(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic send_word(logic kind, logic [INDEX_W-1:0] idx,
                           logic signed [VALUE_W-1:0] val, logic dir,
                           logic typed, out_word_t typed_word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    index_i     <= idx;
    value_i     <= val;
    direction_i <= dir;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == KIND_LOAD) elem_mem[idx] = val;
    else predict_step(dir, typed, typed_word);
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (perm_words_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_length(logic [LEN_W-1:0] len);
    drain_and_settle();
    @(negedge clk_i);
    cfg_valid_i  <= 1'b1;
    cfg_length_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    len_reg = len;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < LimitCyc) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("** lexicographic_permutation_stepper: FAILED **");
    $finish;
  end

  // receiver: random stall stretches, plus long hold-offs on request
  initial begin : receiver
    int run;
    int pct;
    int holds_done;
    int hold_left;
    run = 0;
    pct = 0;
    holds_done = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_done != hold_reqs) begin
        holds_done++;
        hold_left = HoldCyc;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run == 0) begin
          run = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
          endcase
        end
        run--;
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    out_word_t got;
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{position_o, element_o, changed_o, last_o};
      if (perm_words_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word pos %0d elem %0d chg %0b last %0b",
                                got.pos, got.elem, got.changed, got.last));
      end else begin
        want = perm_words_q.pop_front();
        if (got.pos !== want.pos || got.elem !== want.elem ||
            got.changed !== want.changed || got.last !== want.last)
          note_mismatch($sformatf(
            "exp pos %0d elem %0d chg %0b last %0b, got pos %0d elem %0d chg %0b last %0b",
            want.pos, want.elem, want.changed, want.last,
            got.pos, got.elem, got.changed, got.last));
      end
    end
  end

  initial begin : stimulus
    int rnd_items;
    int phase;
    int n;
    int nsteps;
    logic prev;
    logic dupes;
    logic [LEN_W-1:0] len;
    logic signed [VALUE_W-1:0] v;
    fail_cnt     = 0;
    hold_reqs    = 0;
    burst_left   = 0;
    len_reg      = LEN_RESET;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_LOAD;
    index_i      = '0;
    value_i      = '0;
    direction_i  = DIR_NEXT;
    cfg_valid_i  = 1'b0;
    cfg_length_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[r]) begin
      case (dir_tab[r].op)
        ROW_LEN:  set_length(dir_tab[r].val[LEN_W-1:0]);
        ROW_LOAD: send_word(KIND_LOAD, dir_tab[r].idx, dir_tab[r].val, dir_tab[r].dir,
                            1'b0, '0);
        default:  send_word(KIND_STEP, dir_tab[r].idx, dir_tab[r].val, dir_tab[r].dir,
                            dir_tab[r].typed, dir_tab[r].want);
      endcase
    end

    rnd_items = 0;
    phase = 0;
    while (rnd_items < RandItems) begin
      phase++;
      case (phase)
        1: len = 5'd1;
        2: len = 5'd16;
        default: begin
          case ($urandom_range(0, 7))
            0: len = LEN_W'($urandom_range(17, 31));
            1: len = 5'd0;
            default: len = LEN_W'($urandom_range(2, 6));
          endcase
        end
      endcase
      set_length(len);
      n = used_len();
      dupes = $urandom_range(0, 1);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_word(KIND_LOAD, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom),
                    1'b0, '0);
          rnd_items++;
        end
        v = dupes ? VALUE_W'($urandom_range(0, 3) - 2) : VALUE_W'($urandom);
        send_word(KIND_LOAD, INDEX_W'(k), v, 1'($urandom), 1'b0, '0);
        rnd_items++;
      end
      if (phase == 3) begin
        hold_reqs++;
        nsteps = 8;
      end else begin
        nsteps = (n >= 8) ? 3 : $urandom_range(2, 8);
      end
      prev = $urandom_range(0, 1);
      repeat (nsteps) begin
        if ($urandom_range(0, 7) == 0) begin
          send_word(KIND_LOAD, INDEX_W'($urandom_range(0, n - 1)), VALUE_W'($urandom),
                    1'($urandom), 1'b0, '0);
          rnd_items++;
        end
        send_word(KIND_STEP, INDEX_W'($urandom), VALUE_W'($urandom),
                  ($urandom_range(0, 4) == 0) ? ~prev : prev, 1'b0, '0);
        rnd_items++;
      end
    end

    drain_and_settle();
    if (fail_cnt == 0) begin
      $display("** lexicographic_permutation_stepper: PASSED **");
    end else begin
      $display("** lexicographic_permutation_stepper: FAILED **");
    end
    $finish;
  end

endmodule
